/* rtl/core/mrrc_pkg.sv */
package mrrc_pkg;

    localparam logic [8:0]  MAX_FRAME_BYTES = 9'd256;
    localparam logic [6:0]  MAX_READ_REGS   = 7'd125;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [8:0]  EXC_FRAME_LEN   = 9'd5;
    localparam logic [8:0]  WRITE_FRAME_LEN = 9'd8;
    localparam logic [8:0]  READ_OVERHEAD   = 9'd5;
    localparam logic [8:0]  MIN_FRAME_LEN   = 9'd4;
    localparam logic [8:0]  FIRST_DATA_POS  = 9'd3;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 48;

    localparam logic [7:0] FN_READ_HOLDING = 8'h03;
    localparam logic [7:0] FN_READ_INPUT   = 8'h04;
    localparam logic [7:0] FN_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FN_WRITE_MULTI  = 8'h10;

    typedef enum logic
    {
        CMD_ARM  = 1'b0,
        CMD_BYTE = 1'b1
    } cmd_t;

    typedef enum logic
    {
        KIND_REG    = 1'b0,
        KIND_STATUS = 1'b1
    } kind_t;

    typedef enum logic [2:0]
    {
        STAT_OK          = 3'd0,
        STAT_BUSY        = 3'd1,
        STAT_CRC         = 3'd2,
        STAT_INVALID     = 3'd3,
        STAT_UNSUPPORTED = 3'd4,
        STAT_BAD_ARG     = 3'd5,
        STAT_FAIL        = 3'd6
    } status_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic status_t decode_exception(input logic [7:0] code);
        status_t s;
        unique case (code)
            8'd1:          s = STAT_UNSUPPORTED;
            8'd2, 8'd3:    s = STAT_BAD_ARG;
            8'd4, 8'd7, 8'd8: s = STAT_FAIL;
            8'd5, 8'd6:    s = STAT_BUSY;
            default:       s = STAT_INVALID;
        endcase
        return s;
    endfunction

endpackage

/* rtl/core/modbus_rtu_response_checker.sv */
// Timing: an accepted input transaction is held in the input register, and its result
// is then written to the result register, from which it is valid on the master side.
// Throughput: one transaction per cycle while the master side accepts results; an input register and a result register
// bracket a single pass of byte-wide CRC update and field checks.
// Reset: asynchronous, active low; expectation returns to slave 1, function 3,
// zero address, count and value; frame state clears (CRC 0xFFFF, position 0).
module modbus_rtu_response_checker
    import mrrc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // exp_slave, exp_function, exp_address, exp_count, exp_value, resp_byte, pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,   // last_byte
    input  logic                   s_axis_tuser,   // command
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // reg_index, reg_value, status, exc_raw, byte_count, pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser    // kind
);

    logic                  in_valid_reg, in_valid_next;
    cmd_t                  in_cmd_reg;
    logic [IN_TDATA_W-1:0] in_data_reg;
    logic                  in_last_reg;

    logic [7:0]  want_slave_reg, want_slave_next;
    logic [7:0]  want_function_reg, want_function_next;
    logic [15:0] want_address_reg, want_address_next;
    logic [6:0]  want_count_reg, want_count_next;
    logic [15:0] want_value_reg, want_value_next;
    logic [15:0] crc_reg, crc_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  tw0_reg, tw0_next;
    logic [7:0]  tw1_reg, tw1_next;
    logic [7:0]  hold_reg, hold_next;
    logic        mismatch_reg, mismatch_next;
    logic        exc_seen_reg, exc_seen_next;
    logic [7:0]  exc_byte_reg, exc_byte_next;

    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg, out_kind_next;
    logic [6:0]  out_index_reg, out_index_next;
    logic [15:0] out_value_reg, out_value_next;
    status_t     out_status_reg, out_status_next;
    logic [7:0]  out_exc_reg, out_exc_next;
    logic [8:0]  out_len_reg, out_len_next;

    logic        advance;
    logic [7:0]  b;
    logic [8:0]  p;
    logic [8:0]  len;
    logic        in_window;
    logic        is_read;
    logic        is_write;
    logic        count_ok;
    logic [7:0]  count_x2;
    logic [15:0] write_low;
    logic        byte_ok;
    logic        mismatch_upd;
    logic        exc_seen_upd;
    logic [7:0]  exc_byte_upd;
    logic [15:0] crc_upd;
    logic [8:0]  d;
    logic        in_data_span;
    logic        data_byte;
    status_t     fin_status;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    assign b         = in_data_reg[62:55];
    assign p         = pos_reg;
    assign len       = (pos_reg <= MAX_FRAME_BYTES) ? pos_reg + 9'd1 : pos_reg;
    assign in_window = pos_reg < MAX_FRAME_BYTES;
    assign is_read   = (want_function_reg == FN_READ_HOLDING) ||
                       (want_function_reg == FN_READ_INPUT);
    assign is_write  = (want_function_reg == FN_WRITE_SINGLE) ||
                       (want_function_reg == FN_WRITE_MULTI);
    assign count_ok  = (want_count_reg != 7'd0) && (want_count_reg <= MAX_READ_REGS);
    assign count_x2  = {want_count_reg, 1'b0};
    assign write_low = (want_function_reg == FN_WRITE_SINGLE) ? want_value_reg
                                                              : {9'd0, want_count_reg};
    assign crc_upd   = (p >= 9'd2) ? crc_feed(crc_reg, tw0_reg) : crc_reg;
    assign d         = p - FIRST_DATA_POS;
    assign in_data_span = (p >= FIRST_DATA_POS) && (d < {1'b0, count_x2});

    always_comb
    begin
        byte_ok = 1'b1;
        priority if (p == 9'd0)
        begin
            byte_ok = (b == want_slave_reg);
        end
        else if (p == 9'd1)
        begin
            byte_ok = (b == want_function_reg);
        end
        else if (is_read)
        begin
            if (p == 9'd2)
            begin
                byte_ok = (b == count_x2);
            end
        end
        else if (is_write)
        begin
            priority if (p == 9'd2)
            begin
                byte_ok = (b == want_address_reg[15:8]);
            end
            else if (p == 9'd3)
            begin
                byte_ok = (b == want_address_reg[7:0]);
            end
            else if (p == 9'd4)
            begin
                byte_ok = (b == write_low[15:8]);
            end
            else if (p == 9'd5)
            begin
                byte_ok = (b == write_low[7:0]);
            end
            else
            begin
                byte_ok = 1'b1;
            end
        end
        else
        begin
            byte_ok = 1'b1;
        end
    end

    assign mismatch_upd = mismatch_reg || (in_window && !byte_ok);
    assign exc_seen_upd = exc_seen_reg || (in_window && (p == 9'd1) && b[7]);
    assign exc_byte_upd = (in_window && (p == 9'd2)) ? b : exc_byte_reg;
    assign data_byte    = in_window && !in_last_reg && !mismatch_upd && is_read &&
                          count_ok && in_data_span;

    always_comb
    begin
        priority if (len > MAX_FRAME_BYTES)
        begin
            fin_status = STAT_INVALID;
        end
        else if (len < MIN_FRAME_LEN)
        begin
            fin_status = STAT_BUSY;
        end
        else if ({b, tw1_reg} != crc_upd)
        begin
            fin_status = STAT_CRC;
        end
        else if (exc_seen_upd)
        begin
            fin_status = (len != EXC_FRAME_LEN) ? STAT_INVALID : decode_exception(exc_byte_upd);
        end
        else if (is_read)
        begin
            priority if (!count_ok)
            begin
                fin_status = STAT_BAD_ARG;
            end
            else if (mismatch_upd || (len != ({1'b0, count_x2} + READ_OVERHEAD)))
            begin
                fin_status = STAT_INVALID;
            end
            else
            begin
                fin_status = STAT_OK;
            end
        end
        else if (is_write)
        begin
            fin_status = (mismatch_upd || (len != WRITE_FRAME_LEN)) ? STAT_INVALID : STAT_OK;
        end
        else
        begin
            fin_status = STAT_INVALID;
        end
    end

    always_comb
    begin
        want_slave_next    = want_slave_reg;
        want_function_next = want_function_reg;
        want_address_next  = want_address_reg;
        want_count_next    = want_count_reg;
        want_value_next    = want_value_reg;
        crc_next           = crc_reg;
        pos_next           = pos_reg;
        tw0_next           = tw0_reg;
        tw1_next           = tw1_reg;
        hold_next          = hold_reg;
        mismatch_next      = mismatch_reg;
        exc_seen_next      = exc_seen_reg;
        exc_byte_next      = exc_byte_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_kind_next      = out_kind_reg;
        out_index_next     = out_index_reg;
        out_value_next     = out_value_reg;
        out_status_next    = out_status_reg;
        out_exc_next       = out_exc_reg;
        out_len_next       = out_len_reg;

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (in_cmd_reg == CMD_ARM)
            begin
                want_slave_next    = in_data_reg[7:0];
                want_function_next = in_data_reg[15:8];
                want_address_next  = in_data_reg[31:16];
                want_count_next    = in_data_reg[38:32];
                want_value_next    = in_data_reg[54:39];
                crc_next           = CRC_INIT;
                pos_next           = 9'd0;
                tw0_next           = 8'd0;
                tw1_next           = 8'd0;
                hold_next          = 8'd0;
                mismatch_next      = 1'b0;
                exc_seen_next      = 1'b0;
                exc_byte_next      = 8'd0;
            end
            else
            begin
                crc_next      = crc_upd;
                pos_next      = len;
                tw0_next      = tw1_reg;
                tw1_next      = b;
                mismatch_next = mismatch_upd;
                exc_seen_next = exc_seen_upd;
                exc_byte_next = exc_byte_upd;
                out_len_next  = (len > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : len;
                if (data_byte && !d[0])
                begin
                    hold_next = b;
                end
                if (data_byte && d[0])
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_REG;
                    out_index_next  = d[7:1];
                    out_value_next  = {hold_reg, b};
                    out_status_next = STAT_OK;
                    out_exc_next    = 8'd0;
                end
                else if (in_last_reg)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_STATUS;
                    out_index_next  = 7'd0;
                    out_value_next  = 16'd0;
                    out_status_next = fin_status;
                    out_exc_next    = exc_seen_upd ? exc_byte_upd : 8'd0;
                    // clear frame state for the next response
                    crc_next        = CRC_INIT;
                    pos_next        = 9'd0;
                    tw0_next        = 8'd0;
                    tw1_next        = 8'd0;
                    hold_next       = 8'd0;
                    mismatch_next   = 1'b0;
                    exc_seen_next   = 1'b0;
                    exc_byte_next   = 8'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_slave_reg    <= 8'd1;
            want_function_reg <= FN_READ_HOLDING;
            want_address_reg  <= 16'd0;
            want_count_reg    <= 7'd0;
            want_value_reg    <= 16'd0;
            crc_reg           <= CRC_INIT;
            pos_reg           <= 9'd0;
            tw0_reg           <= 8'd0;
            tw1_reg           <= 8'd0;
            hold_reg          <= 8'd0;
            mismatch_reg      <= 1'b0;
            exc_seen_reg      <= 1'b0;
            exc_byte_reg      <= 8'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            want_slave_reg    <= want_slave_next;
            want_function_reg <= want_function_next;
            want_address_reg  <= want_address_next;
            want_count_reg    <= want_count_next;
            want_value_reg    <= want_value_next;
            crc_reg           <= crc_next;
            pos_reg           <= pos_next;
            tw0_reg           <= tw0_next;
            tw1_reg           <= tw1_next;
            hold_reg          <= hold_next;
            mismatch_reg      <= mismatch_next;
            exc_seen_reg      <= exc_seen_next;
            exc_byte_reg      <= exc_byte_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_index_reg  <= out_index_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_exc_reg    <= out_exc_next;
        out_len_reg    <= out_len_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {5'd0, out_len_reg, out_exc_reg, out_status_reg,
                            out_value_reg, out_index_reg};

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_FRAME_BYTES + 9'd1)
        else $error("frame position past saturation");

    a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 9'd2 |-> crc_reg == CRC_INIT)
        else $error("CRC advanced before third byte");

    a_status_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_STATUS |->
        out_index_reg == 7'd0 && out_value_reg == 16'd0)
        else $error("status result carries register fields");

    a_ok_no_exc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_STATUS && out_status_reg == STAT_OK |->
        out_exc_reg == 8'd0 && out_len_reg >= MIN_FRAME_LEN)
        else $error("ok status with exception or short frame");

    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_cmd_reg == CMD_BYTE && in_last_reg |=> pos_reg == 9'd0)
        else $error("frame state not cleared after last byte");

endmodule

/* bench/mrrc_checker.sv */
package mrrc_tb_pkg;

    import mrrc_pkg::*;

    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

module mrrc_checker
    import mrrc_pkg::*;
    import mrrc_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    input  logic                   s_axis_tuser,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   m_axis_tuser,
    input  logic                   end_of_test,
    output int                     failures,
    output int                     outstanding,
    output int                     reg_count,
    output int                     status_count,
    output logic [7:0]             status_seen
);

    localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;
    localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'd4;
    localparam logic [7:0] EXC_ACKNOWLEDGE      = 8'd5;
    localparam logic [7:0] EXC_DEVICE_BUSY      = 8'd6;
    localparam logic [7:0] EXC_NEGATIVE_ACK     = 8'd7;
    localparam logic [7:0] EXC_PARITY_ERROR     = 8'd8;
    localparam int         MAX_REPORTS          = 10;

    typedef struct packed
    {
        kind_t       kind;
        logic [6:0]  idx;
        logic [15:0] val;
        status_t     st;
        logic [7:0]  exc;
        logic [8:0]  flen;
    } reply_t;

    reply_t      expected_q[$];

    logic [7:0]  arm_slave     = 8'd1;
    logic [7:0]  arm_func      = FN_READ_HOLDING;
    logic [15:0] arm_addr      = 16'd0;
    logic [6:0]  arm_count     = 7'd0;
    logic [15:0] arm_value     = 16'd0;
    logic [15:0] crc_acc       = CRC_INIT;
    int          byte_pos      = 0;
    logic [7:0]  crc_lo        = 8'd0;
    logic [7:0]  crc_hi        = 8'd0;
    logic [7:0]  data_hi       = 8'd0;
    bit          mismatch_seen = 1'b0;
    bit          exc_flag      = 1'b0;
    logic [7:0]  exc_code      = 8'd0;

    int          err_total     = 0;
    int          regs_total    = 0;
    int          stats_total   = 0;
    logic [7:0]  stat_mask     = 8'd0;
    bit          closed        = 1'b0;

    function automatic bit arm_is_read();
        return arm_func == FN_READ_HOLDING || arm_func == FN_READ_INPUT;
    endfunction

    function automatic bit arm_count_valid();
        return arm_count >= 7'd1 && arm_count <= MAX_READ_REGS;
    endfunction

    function automatic bit frame_byte_ok(input int p, input logic [7:0] b);
        logic [15:0] echo_low;
        echo_low = (arm_func == FN_WRITE_SINGLE) ? arm_value : {9'd0, arm_count};
        if (p == 0)
        begin
            return b == arm_slave;
        end
        if (p == 1)
        begin
            return b == arm_func;
        end
        if (arm_is_read())
        begin
            return (p != 2) || (b == {arm_count, 1'b0});
        end
        if (arm_func == FN_WRITE_SINGLE || arm_func == FN_WRITE_MULTI)
        begin
            case (p)
                2:       return b == arm_addr[15:8];
                3:       return b == arm_addr[7:0];
                4:       return b == echo_low[15:8];
                5:       return b == echo_low[7:0];
                default: return 1'b1;
            endcase
        end
        return 1'b1;
    endfunction

    function automatic status_t exception_status(input logic [7:0] code);
        case (code)
            EXC_ILLEGAL_FUNCTION:                  return STAT_UNSUPPORTED;
            EXC_ILLEGAL_ADDRESS, EXC_ILLEGAL_VALUE: return STAT_BAD_ARG;
            EXC_DEVICE_FAILURE, EXC_NEGATIVE_ACK,
            EXC_PARITY_ERROR:                      return STAT_FAIL;
            EXC_ACKNOWLEDGE, EXC_DEVICE_BUSY:      return STAT_BUSY;
            default:                               return STAT_INVALID;
        endcase
    endfunction

    function automatic status_t frame_verdict(input int len);
        if (len > int'(MAX_FRAME_BYTES))
        begin
            return STAT_INVALID;
        end
        if (len < int'(MIN_FRAME_LEN))
        begin
            return STAT_BUSY;
        end
        if ({crc_hi, crc_lo} != crc_acc)
        begin
            return STAT_CRC;
        end
        if (exc_flag)
        begin
            return (len != int'(EXC_FRAME_LEN)) ? STAT_INVALID : exception_status(exc_code);
        end
        if (arm_is_read())
        begin
            if (!arm_count_valid())
            begin
                return STAT_BAD_ARG;
            end
            if (mismatch_seen || len != 2 * int'(arm_count) + int'(READ_OVERHEAD))
            begin
                return STAT_INVALID;
            end
            return STAT_OK;
        end
        if (arm_func == FN_WRITE_SINGLE || arm_func == FN_WRITE_MULTI)
        begin
            return (mismatch_seen || len != int'(WRITE_FRAME_LEN)) ? STAT_INVALID : STAT_OK;
        end
        return STAT_INVALID;
    endfunction

    task automatic restart_frame();
        crc_acc       = CRC_INIT;
        byte_pos      = 0;
        crc_lo        = 8'd0;
        crc_hi        = 8'd0;
        data_hi       = 8'd0;
        mismatch_seen = 1'b0;
        exc_flag      = 1'b0;
        exc_code      = 8'd0;
    endtask

    task automatic absorb_transaction();
        reply_t     r;
        int         p;
        int         len;
        logic [7:0] b;
        bit         clean;
        if (s_axis_tuser == CMD_ARM)
        begin
            arm_slave = s_axis_tdata[7:0];
            arm_func  = s_axis_tdata[15:8];
            arm_addr  = s_axis_tdata[31:16];
            arm_count = s_axis_tdata[38:32];
            arm_value = s_axis_tdata[54:39];
            restart_frame();
            return;
        end
        b = s_axis_tdata[62:55];
        p = byte_pos;
        if (byte_pos <= int'(MAX_FRAME_BYTES))
        begin
            byte_pos++;
        end
        len = byte_pos;
        if (p >= 2)
        begin
            crc_acc = crc16_update(crc_acc, crc_lo);
        end
        crc_lo = crc_hi;
        crc_hi = b;

        r      = '0;
        r.kind = KIND_REG;
        r.st   = STAT_OK;
        r.flen = (len > int'(MAX_FRAME_BYTES)) ? MAX_FRAME_BYTES : 9'(len);

        if (p < int'(MAX_FRAME_BYTES))
        begin
            clean = !mismatch_seen;
            if (p == 1 && b[7])
            begin
                exc_flag = 1'b1;
            end
            if (p == 2)
            begin
                exc_code = b;
            end
            if (!frame_byte_ok(p, b))
            begin
                mismatch_seen = 1'b1;
            end
            if (!s_axis_tlast && clean && !mismatch_seen && arm_is_read() && arm_count_valid()
                && p >= int'(FIRST_DATA_POS) && p - 3 < 2 * int'(arm_count))
            begin
                if (((p - 3) % 2) == 0)
                begin
                    data_hi = b;
                end
                else
                begin
                    r.idx = 7'((p - 3) / 2);
                    r.val = {data_hi, b};
                    expected_q.push_back(r);
                    return;
                end
            end
        end

        if (s_axis_tlast)
        begin
            r.kind = KIND_STATUS;
            r.st   = frame_verdict(len);
            r.exc  = exc_flag ? exc_code : 8'd0;
            expected_q.push_back(r);
            restart_frame();
        end
    endtask

    task automatic check_reply();
        reply_t got;
        reply_t want;
        got.kind = kind_t'(m_axis_tuser);
        got.idx  = m_axis_tdata[6:0];
        got.val  = m_axis_tdata[22:7];
        got.st   = status_t'(m_axis_tdata[25:23]);
        got.exc  = m_axis_tdata[33:26];
        got.flen = m_axis_tdata[42:34];
        if (got.kind == KIND_REG)
        begin
            regs_total++;
        end
        else
        begin
            stats_total++;
            stat_mask[got.st] = 1'b1;
        end
        if (expected_q.size() == 0)
        begin
            err_total++;
            if (err_total <= MAX_REPORTS)
            begin
                $display("[%0t] unexpected result: kind %0d index %0d value %h status %0d",
                         $realtime, got.kind, got.idx, got.val, got.st);
            end
            return;
        end
        want = expected_q.pop_front();
        if (got.kind != want.kind || got.idx != want.idx || got.val != want.val
            || got.st != want.st || got.exc != want.exc || got.flen != want.flen)
        begin
            err_total++;
            if (err_total <= MAX_REPORTS)
            begin
                $display("[%0t] mismatch (exp/act): kind %0d/%0d index %0d/%0d value %h/%h",
                         $realtime, want.kind, got.kind, want.idx, got.idx, want.val, got.val);
                $display("    status %0d/%0d exception %h/%h length %0d/%0d",
                         want.st, got.st, want.exc, got.exc, want.flen, got.flen);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            arm_slave = 8'd1;
            arm_func  = FN_READ_HOLDING;
            arm_addr  = 16'd0;
            arm_count = 7'd0;
            arm_value = 16'd0;
            restart_frame();
            expected_q.delete();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                absorb_transaction();
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                check_reply();
            end
            if (end_of_test && !closed)
            begin
                closed = 1'b1;
                if (expected_q.size() != 0)
                begin
                    err_total += expected_q.size();
                    $display("%0d expected results never arrived", expected_q.size());
                end
            end
        end
        failures     <= err_total;
        outstanding  <= expected_q.size();
        reg_count    <= regs_total;
        status_count <= stats_total;
        status_seen  <= stat_mask;
    end

endmodule

/* bench/tb_top.sv */
module tb_top;

    import mrrc_pkg::*;
    import mrrc_tb_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int ITEMS_TOTAL = 1200;

    typedef enum int
    {
        ARM_READ,
        ARM_WRITE,
        ARM_BAD_COUNT,
        ARM_UNKNOWN
    } arm_kind_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   end_of_test;

    int                     failures;
    int                     outstanding;
    int                     reg_count;
    int                     status_count;
    logic [7:0]             status_seen;

    int                     src_idle_pct  = 30;
    int                     sink_idle_pct = 54;
    int                     holds_asked   = 0;
    int                     holds_served  = 0;
    int                     items_sent    = 0;
    int                     frames_sent   = 0;
    int                     quiet_cycles  = 0;
    bit                     armed_once    = 1'b0;

    logic [7:0]             cur_slave;
    logic [7:0]             cur_func;
    logic [15:0]            cur_addr;
    logic [6:0]             cur_count;
    logic [15:0]            cur_value;
    logic [7:0]             frame_q[$];

    modbus_rtu_response_checker u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    mrrc_checker u_chk
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .end_of_test   (end_of_test),
        .failures      (failures),
        .outstanding   (outstanding),
        .reg_count     (reg_count),
        .status_count  (status_count),
        .status_seen   (status_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // hold off the result channel for a long stretch when asked
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_served)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end
            else
            begin
                m_axis_tready <= rst_n && ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_txn(input cmd_t cmd, input logic [7:0] slave, input logic [7:0] func,
                            input logic [15:0] addr, input logic [6:0] cnt,
                            input logic [15:0] val, input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {1'b0, b, val, cnt, addr, func, slave};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        push_txn(CMD_BYTE, 8'($urandom_range(1, 247)), 8'($urandom), 16'($urandom),
                 7'($urandom_range(125)), 16'($urandom), b, last);
    endtask

    task automatic send_arm();
        push_txn(CMD_ARM, cur_slave, cur_func, cur_addr, cur_count, cur_value,
                 8'($urandom), 1'($urandom));
        armed_once = 1'b1;
    endtask

    task automatic send_bytes(input int count, input bit mark_end);
        for (int i = 0; i < count; i++)
        begin
            send_byte(frame_q[i], mark_end && (i == count - 1));
        end
    endtask

    task automatic pick_expectation(input arm_kind_t k);
        cur_slave = 8'($urandom_range(1, 247));
        cur_addr  = 16'($urandom);
        cur_value = 16'($urandom);
        cur_count = 7'($urandom_range(125));
        case (k)
            ARM_READ:
            begin
                cur_func  = $urandom_range(1) ? FN_READ_HOLDING : FN_READ_INPUT;
                cur_count = ($urandom_range(99) < 3) ? 7'($urandom_range(9, 40))
                                                     : 7'($urandom_range(1, 8));
            end
            ARM_WRITE:
            begin
                cur_func = $urandom_range(1) ? FN_WRITE_SINGLE : FN_WRITE_MULTI;
            end
            ARM_BAD_COUNT:
            begin
                cur_func  = $urandom_range(1) ? FN_READ_HOLDING : FN_READ_INPUT;
                cur_count = 7'd0;
            end
            default:
            begin
                cur_func = 8'($urandom);
            end
        endcase
    endtask

    task automatic build_reply();
        logic [15:0] echo_low;
        echo_low = (cur_func == FN_WRITE_SINGLE) ? cur_value : {9'd0, cur_count};
        frame_q.delete();
        frame_q.push_back(cur_slave);
        frame_q.push_back(cur_func);
        if (cur_func == FN_READ_HOLDING || cur_func == FN_READ_INPUT)
        begin
            frame_q.push_back({cur_count, 1'b0});
            for (int i = 0; i < 2 * int'(cur_count); i++)
            begin
                frame_q.push_back(8'($urandom));
            end
        end
        else
        begin
            frame_q.push_back(cur_addr[15:8]);
            frame_q.push_back(cur_addr[7:0]);
            frame_q.push_back(echo_low[15:8]);
            frame_q.push_back(echo_low[7:0]);
        end
    endtask

    task automatic build_exception(input logic [7:0] code);
        frame_q.delete();
        frame_q.push_back(cur_slave);
        frame_q.push_back(cur_func | 8'h80);
        frame_q.push_back(code);
    endtask

    task automatic seal_frame();
        logic [15:0] c;
        c = CRC_INIT;
        foreach (frame_q[i])
        begin
            c = crc16_update(c, frame_q[i]);
        end
        frame_q.push_back(c[7:0]);
        frame_q.push_back(c[15:8]);
    endtask

    task automatic mangle_frame();
        int at;
        at = $urandom_range(frame_q.size() - 1);
        case ($urandom_range(4))
            0:       frame_q[at] = 8'($urandom);
            1:       frame_q[at] = frame_q[at] ^ 8'(1 << $urandom_range(7));
            2:
            begin
                if (frame_q.size() > 1)
                begin
                    frame_q.delete(at);
                end
            end
            3:       frame_q.insert(at, 8'($urandom));
            default: frame_q.push_back(8'($urandom));
        endcase
    endtask

    task automatic random_frame();
        int sel;
        int keep;
        sel = $urandom_range(99);
        if (!armed_once || $urandom_range(99) >= 15)
        begin
            if (sel < 50)
            begin
                pick_expectation(ARM_READ);
            end
            else if (sel < 78)
            begin
                pick_expectation(ARM_WRITE);
            end
            else if (sel < 88)
            begin
                pick_expectation(ARM_BAD_COUNT);
            end
            else
            begin
                pick_expectation(ARM_UNKNOWN);
            end
            send_arm();
        end

        sel = $urandom_range(99);
        if (sel < 14)
        begin
            build_exception(($urandom_range(99) < 80) ? 8'($urandom_range(10)) : 8'($urandom));
        end
        else if (sel < 22)
        begin
            frame_q.delete();
            repeat ($urandom_range(1, 12))
            begin
                frame_q.push_back(8'($urandom));
            end
        end
        else
        begin
            build_reply();
        end

        if (sel >= 14 && sel < 22)
        begin
            if ($urandom_range(1))
            begin
                seal_frame();
            end
        end
        else
        begin
            if ($urandom_range(99) < 20)
            begin
                mangle_frame();
            end
            seal_frame();
            if ($urandom_range(99) < 5)
            begin
                keep = frame_q.size() - 1 - $urandom_range(1);
                frame_q[keep] = frame_q[keep] ^ 8'(1 << $urandom_range(7));
            end
            if ($urandom_range(99) < 4)
            begin
                keep = $urandom_range(1, frame_q.size() - 1);
                while (frame_q.size() > keep)
                begin
                    void'(frame_q.pop_back());
                end
            end
        end

        // drop a partial frame by re-arming in the middle of it
        if ($urandom_range(99) < 6 && frame_q.size() > 1)
        begin
            send_bytes($urandom_range(1, frame_q.size() - 1), 1'b0);
            send_arm();
        end
        send_bytes(frame_q.size(), 1'b1);
        frames_sent++;
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        end_of_test   = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = CMD_ARM;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // response under the reset expectation: read with zero count
        cur_slave = 8'd1;
        cur_func  = FN_READ_HOLDING;
        cur_addr  = 16'd0;
        cur_count = 7'd0;
        cur_value = 16'd0;
        build_reply();
        seal_frame();
        send_bytes(frame_q.size(), 1'b1);

        // single byte frame is too short
        send_byte(8'h01, 1'b1);

        cur_slave = 8'd247;
        cur_func  = FN_READ_INPUT;
        cur_addr  = 16'hFFFF;
        cur_count = 7'd1;
        cur_value = 16'hFFFF;
        send_arm();
        build_reply();
        frame_q[3] = 8'hFF;
        frame_q[4] = 8'h00;
        seal_frame();
        send_bytes(frame_q.size(), 1'b1);

        cur_slave = 8'd1;
        cur_func  = FN_READ_HOLDING;
        cur_count = MAX_READ_REGS;
        send_arm();
        build_exception(8'd2);
        seal_frame();
        send_bytes(frame_q.size(), 1'b1);

        cur_func  = FN_WRITE_SINGLE;
        cur_addr  = 16'h1234;
        cur_value = 16'hABCD;
        send_arm();
        build_reply();
        seal_frame();
        send_bytes(frame_q.size(), 1'b1);
        frames_sent += 5;

        holds_asked++;
        while (items_sent < 200)
        begin
            random_frame();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        while (items_sent < 420)
        begin
            random_frame();
        end

        src_idle_pct  = 54;
        sink_idle_pct = 30;
        while (items_sent < 820)
        begin
            random_frame();
        end

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        // full read past the frame size limit
        cur_slave = 8'($urandom_range(1, 247));
        cur_func  = FN_READ_HOLDING;
        cur_count = MAX_READ_REGS;
        send_arm();
        build_reply();
        repeat (5)
        begin
            frame_q.push_back(8'($urandom));
        end
        seal_frame();
        send_bytes(frame_q.size(), 1'b1);
        frames_sent++;
        while (items_sent < ITEMS_TOTAL)
        begin
            random_frame();
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Drove %0d transactions in %0d frames under three backpressure mixes.",
                 items_sent, frames_sent);
        $display("Checked %0d register and %0d status results; status codes hit: %b",
                 reg_count, status_count, status_seen);
        if (failures == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
